@@ hw/rtl/minv_pkg.sv @@
package minv_pkg;

    localparam int DIM     = 3;
    localparam int NELEM   = DIM * DIM;
    localparam int ELEM_W  = 32;
    // |cofactor| < 2^63; one spare bit keeps negation safe
    localparam int COF_W   = 2 * ELEM_W + 1;
    // |det| < 3 * 2^95
    localparam int DET_W   = 3 * ELEM_W + 3;

    localparam int COF_LAT = 2;
    localparam int DET_LAT = 2;
    // prep, overflow check, one stage per quotient bit, saturate
    localparam int DIV_LAT = ELEM_W + 3;

    typedef logic signed [ELEM_W-1:0]   t_elem;
    typedef logic signed [COF_W-1:0]    t_cof;
    typedef logic signed [DET_W-1:0]    t_det;
    typedef logic signed [2*ELEM_W-1:0] t_prod;

endpackage

@@ hw/rtl/minv_cofactor.sv @@
module minv_cofactor (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  minv_pkg::t_elem      i_a    [minv_pkg::NELEM],
    output minv_pkg::t_cof       o_cof  [minv_pkg::NELEM],
    output minv_pkg::t_elem      o_row0 [minv_pkg::DIM]
);

    minv_pkg::t_prod r_pa [minv_pkg::NELEM];
    minv_pkg::t_prod r_pb [minv_pkg::NELEM];
    minv_pkg::t_cof  r_cof [minv_pkg::NELEM];
    minv_pkg::t_elem r_row0_d1 [minv_pkg::DIM];
    minv_pkg::t_elem r_row0_d2 [minv_pkg::DIM];

    for (genvar r = 0; r < minv_pkg::DIM; r++) begin : g_row
        for (genvar c = 0; c < minv_pkg::DIM; c++) begin : g_col
            localparam int R0  = (r == 0) ? 1 : 0;
            localparam int R1  = (r == 2) ? 1 : 2;
            localparam int C0  = (c == 0) ? 1 : 0;
            localparam int C1  = (c == 2) ? 1 : 2;
            localparam int E   = r * minv_pkg::DIM + c;
            localparam bit ODD = ((r + c) % 2) == 1;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[E] <= i_a[R0 * minv_pkg::DIM + C0] * i_a[R1 * minv_pkg::DIM + C1];
                    r_pb[E] <= i_a[R0 * minv_pkg::DIM + C1] * i_a[R1 * minv_pkg::DIM + C0];
                    // fold the checkerboard sign into the subtraction order
                    if (ODD) begin
                        r_cof[E] <= minv_pkg::t_cof'(r_pb[E]) - minv_pkg::t_cof'(r_pa[E]);
                    end else begin
                        r_cof[E] <= minv_pkg::t_cof'(r_pa[E]) - minv_pkg::t_cof'(r_pb[E]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < minv_pkg::DIM; j++) begin
                r_row0_d1[j] <= i_a[j];
                r_row0_d2[j] <= r_row0_d1[j];
            end
        end
    end

    assign o_cof  = r_cof;
    assign o_row0 = r_row0_d2;

endmodule

@@ hw/rtl/minv_det.sv @@
module minv_det (
    input  logic             i_clk,
    input  logic             i_en,
    input  minv_pkg::t_cof   i_cof  [minv_pkg::NELEM],
    input  minv_pkg::t_elem  i_row0 [minv_pkg::DIM],
    output minv_pkg::t_cof   o_cof  [minv_pkg::NELEM],
    output minv_pkg::t_det   o_det
);

    logic signed [minv_pkg::COF_W-1:0] r_plo [minv_pkg::DIM];
    logic signed [minv_pkg::COF_W-1:0] r_phi [minv_pkg::DIM];
    minv_pkg::t_cof r_cof_d1 [minv_pkg::NELEM];
    minv_pkg::t_cof r_cof_d2 [minv_pkg::NELEM];
    minv_pkg::t_det r_det;
    minv_pkg::t_det n_det;

    // split each 65-bit cofactor into two partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < minv_pkg::DIM; j++) begin
                r_plo[j] <= i_row0[j]
                          * $signed({1'b0, i_cof[j][minv_pkg::ELEM_W-1:0]});
                r_phi[j] <= i_row0[j]
                          * $signed(i_cof[j][minv_pkg::COF_W-1:minv_pkg::ELEM_W]);
            end
            r_cof_d1 <= i_cof;
            r_cof_d2 <= r_cof_d1;
            r_det    <= n_det;
        end
    end

    always_comb begin
        minv_pkg::t_det t_hi;
        minv_pkg::t_det t_lo;
        n_det = '0;
        for (int j = 0; j < minv_pkg::DIM; j++) begin
            t_hi  = minv_pkg::t_det'(r_phi[j]);
            t_lo  = minv_pkg::t_det'(r_plo[j]);
            n_det = n_det + (t_hi <<< minv_pkg::ELEM_W) + t_lo;
        end
    end

    assign o_cof = r_cof_d2;
    assign o_det = r_det;

endmodule

@@ hw/rtl/minv_div_lane.sv @@
module minv_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  minv_pkg::t_cof   i_cof,
    input  minv_pkg::t_det   i_det,
    output minv_pkg::t_elem  o_res,
    output logic             o_clip,
    output logic             o_zero
);

    localparam int QW = minv_pkg::ELEM_W;
    localparam int NW = minv_pkg::COF_W - 1 + FRAC_BITS;
    localparam int DW = minv_pkg::DET_W - 1;
    localparam int CW = DW + QW;

    logic [minv_pkg::COF_W-1:0] cof_abs;
    logic [minv_pkg::DET_W-1:0] det_abs;

    logic [NW-1:0] r_rem   [0:QW];
    logic [DW-1:0] r_dmag  [0:QW];
    logic          r_qneg  [0:QW+1];
    logic          r_zero  [0:QW+1];
    logic          r_ovf   [1:QW+1];
    logic [QW-1:0] r_quo   [1:QW+1];

    minv_pkg::t_elem r_res;
    logic            r_clip;
    logic            r_zero_out;

    assign cof_abs = i_cof[minv_pkg::COF_W-1] ? -i_cof : i_cof;
    assign det_abs = i_det[minv_pkg::DET_W-1] ? -i_det : i_det;

    // magnitudes, quotient sign and zero-determinant flag
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {cof_abs[minv_pkg::COF_W-2:0], {FRAC_BITS{1'b0}}};
            r_dmag[0] <= det_abs[DW-1:0];
            r_qneg[0] <= i_cof[minv_pkg::COF_W-1] ^ i_det[minv_pkg::DET_W-1];
            r_zero[0] <= (i_det == '0);
        end
    end

    // quotient of 2^32 or more saturates whatever the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[1]  <= r_rem[0];
            r_dmag[1] <= r_dmag[0];
            r_qneg[1] <= r_qneg[0];
            r_zero[1] <= r_zero[0];
            r_ovf[1]  <= CW'(r_rem[0]) >= {r_dmag[0], {QW{1'b0}}};
            r_quo[1]  <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rem_ext;
        logic [CW-1:0] diff;
        logic          ge;
        logic [QW-1:0] n_quo;

        always_comb begin
            dsh       = CW'(r_dmag[k+1]) << B;
            rem_ext   = CW'(r_rem[k+1]);
            diff      = rem_ext - dsh;
            ge        = rem_ext >= dsh;
            n_quo     = r_quo[k+1];
            n_quo[B]  = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+2]  <= n_quo;
                r_ovf[k+2]  <= r_ovf[k+1];
                r_qneg[k+2] <= r_qneg[k+1];
                r_zero[k+2] <= r_zero[k+1];
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+2]  <= ge ? diff[NW-1:0] : r_rem[k+1];
                    r_dmag[k+2] <= r_dmag[k+1];
                end
            end
        end
    end

    // apply sign, saturate, force zero on a singular matrix
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] q;
        logic          qn;
        logic          big;
        if (i_en) begin
            q   = r_quo[QW+1];
            qn  = r_qneg[QW+1];
            big = r_ovf[QW+1] || (qn ? (q > {1'b1, {(QW-1){1'b0}}}) : q[QW-1]);
            if (r_zero[QW+1]) begin
                r_res <= '0;
            end else if (big) begin
                r_res <= qn ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
            end else begin
                r_res <= qn ? -q : q;
            end
            r_clip     <= !r_zero[QW+1] && big;
            r_zero_out <= r_zero[QW+1];
        end
    end

    assign o_res  = r_res;
    assign o_clip = r_clip;
    assign o_zero = r_zero_out;

endmodule

@@ hw/rtl/matrix_inverse_3x3_unit.sv @@
// Channel | Signals                                  | Direction
// input   | i_in_valid/o_in_ready, i_a_00 .. i_a_22   | one 3x3 matrix per transfer
// output  | o_out_valid/i_out_ready, o_inv_00 .. o_inv_22, o_singular, o_clipped
//
// One matrix per cycle sustained while the output does not stall. A result
// passes 2 cofactor, 2 determinant and 35 divider stages (prep, overflow
// check, one per quotient bit, saturate; nine lanes), then one output register.
// Reset (i_rst_n low, synchronous) empties the pipeline and output stage.
// When the output stalls, a skid register takes one more result and then the
// whole pipeline holds; o_in_ready comes straight from that skid flag.
module matrix_inverse_3x3_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  minv_pkg::t_elem      i_a_00,
    input  minv_pkg::t_elem      i_a_01,
    input  minv_pkg::t_elem      i_a_02,
    input  minv_pkg::t_elem      i_a_10,
    input  minv_pkg::t_elem      i_a_11,
    input  minv_pkg::t_elem      i_a_12,
    input  minv_pkg::t_elem      i_a_20,
    input  minv_pkg::t_elem      i_a_21,
    input  minv_pkg::t_elem      i_a_22,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output minv_pkg::t_elem      o_inv_00,
    output minv_pkg::t_elem      o_inv_01,
    output minv_pkg::t_elem      o_inv_02,
    output minv_pkg::t_elem      o_inv_10,
    output minv_pkg::t_elem      o_inv_11,
    output minv_pkg::t_elem      o_inv_12,
    output minv_pkg::t_elem      o_inv_20,
    output minv_pkg::t_elem      o_inv_21,
    output minv_pkg::t_elem      o_inv_22,
    output logic                 o_singular,
    output logic                 o_clipped
);

    localparam int LAT = minv_pkg::COF_LAT + minv_pkg::DET_LAT + minv_pkg::DIV_LAT;
    localparam int N   = minv_pkg::NELEM;

    logic            en;
    logic            last;
    minv_pkg::t_elem a     [N];
    minv_pkg::t_cof  cof_s [N];
    minv_pkg::t_elem row0  [minv_pkg::DIM];
    minv_pkg::t_cof  cof_d [N];
    minv_pkg::t_det  det;
    minv_pkg::t_elem res   [N];
    logic [N-1:0]    clip;
    logic [N-1:0]    zero;

    logic [LAT-1:0]  r_vld;
    logic            r_out_vld;
    logic            r_skd_vld;
    minv_pkg::t_elem r_out_inv [N];
    logic            r_out_sing;
    logic            r_out_clip;
    minv_pkg::t_elem r_skd_inv [N];
    logic            r_skd_sing;
    logic            r_skd_clip;

    assign a = '{i_a_00, i_a_01, i_a_02, i_a_10, i_a_11, i_a_12, i_a_20, i_a_21, i_a_22};

    assign en         = !r_skd_vld;
    assign o_in_ready = en;
    assign last       = en && r_vld[LAT-1];

    minv_cofactor u_cof (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (a),
        .o_cof  (cof_s),
        .o_row0 (row0)
    );

    minv_det u_det (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cof  (cof_s),
        .i_row0 (row0),
        .o_cof  (cof_d),
        .o_det  (det)
    );

    // lane (i,j) divides cofactor (j,i): the transpose is in the wiring
    for (genvar i = 0; i < minv_pkg::DIM; i++) begin : g_li
        for (genvar j = 0; j < minv_pkg::DIM; j++) begin : g_lj
            minv_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_cof  (cof_d[j * minv_pkg::DIM + i]),
                .i_det  (det),
                .o_res  (res[i * minv_pkg::DIM + j]),
                .o_clip (clip[i * minv_pkg::DIM + j]),
                .o_zero (zero[i * minv_pkg::DIM + j])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
            if (r_skd_vld) begin
                if (i_out_ready) begin
                    r_skd_vld <= 1'b0;
                end
            end else if (last) begin
                if (!r_out_vld || i_out_ready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skd_vld <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // merge lanes: all lanes share one determinant, so lane 0 speaks for singular
    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (i_out_ready) begin
                r_out_inv  <= r_skd_inv;
                r_out_sing <= r_skd_sing;
                r_out_clip <= r_skd_clip;
            end
        end else if (last) begin
            if (!r_out_vld || i_out_ready) begin
                r_out_inv  <= res;
                r_out_sing <= zero[0];
                r_out_clip <= |clip;
            end else begin
                r_skd_inv  <= res;
                r_skd_sing <= zero[0];
                r_skd_clip <= |clip;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_inv_00    = r_out_inv[0];
    assign o_inv_01    = r_out_inv[1];
    assign o_inv_02    = r_out_inv[2];
    assign o_inv_10    = r_out_inv[3];
    assign o_inv_11    = r_out_inv[4];
    assign o_inv_12    = r_out_inv[5];
    assign o_inv_20    = r_out_inv[6];
    assign o_inv_21    = r_out_inv[7];
    assign o_inv_22    = r_out_inv[8];
    assign o_singular  = r_out_sing;
    assign o_clipped   = r_out_clip;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid holds a result while output is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready && last) |=> r_skd_vld)
        else $error("result dropped on output stall");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sing) |-> (!r_out_clip && r_out_inv[0] == '0
            && r_out_inv[4] == '0 && r_out_inv[8] == '0))
        else $error("singular result carries nonzero data");

endmodule
